/* design/ggvc_pkg.sv */
// ----------------------------------------------------------------------------
// Go-to-goal controller package
// Shared widths, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ggvc_pkg;

	localparam int FRAC_BITS    = 12;
	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_LEN     = 24;

	localparam int POS_W   = 16;
	localparam int HD_W    = 15;
	localparam int GAIN_W  = 15;
	localparam int D_W     = 17;
	localparam int RAD_W   = 33;
	localparam int ROOT_W  = 17;
	localparam int SQRT_STEPS = ROOT_W;
	localparam int CX_W    = 32;
	localparam int Z_W     = 34;
	localparam int PRE_SH  = 12;
	localparam int SPEED_W = 13;
	localparam int TURN_W  = 18;
	localparam int BRG_W   = 18;
	localparam int DIFF_W  = 20;

	localparam longint ONE_Q       = 64'sd1 <<< FRAC_BITS;
	localparam longint ARRIVE_Q    = (ONE_Q + 5) / 10;
	localparam longint ARRIVE_SQ   = ARRIVE_Q * ARRIVE_Q;
	localparam longint GATE_Q      = (9 * ONE_Q + 5) / 10;
	localparam longint SPEED_CAP_Q = (3 * ONE_Q) / 2;
	localparam longint PI_Q30      = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam int     ANG_SH      = 30 - FRAC_BITS;
	localparam longint PI_Q        = (PI_Q30 + (64'sd1 <<< (ANG_SH - 1))) >>> ANG_SH;
	localparam longint TURN_MAX    = 131071;
	localparam longint TURN_MIN    = -131072;

	localparam logic signed [Z_W-1:0] ATAN_Q30 [ATAN_LEN] = '{
		34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
		34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
		34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
		34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
		34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
		34'sd1024,      34'sd512,       34'sd256,       34'sd128
	};

	typedef enum logic [1:0] {
		REG_TARGET_X  = 2'd0,
		REG_TARGET_Y  = 2'd1,
		REG_LIN_GAIN  = 2'd2,
		REG_TURN_GAIN = 2'd3
	} reg_idx_t;

endpackage

/* design/ggvc_sqrt.sv */
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage; stages past the last bit only delay the word.
// ----------------------------------------------------------------------------
module ggvc_sqrt #(
	parameter int LAT = ggvc_pkg::SQRT_STEPS
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [ggvc_pkg::RAD_W-1:0]    radicand,
	output logic [ggvc_pkg::ROOT_W-1:0]   root
);

	localparam int VW   = 2 * ggvc_pkg::SQRT_STEPS;
	localparam int RW   = ggvc_pkg::ROOT_W + 2;
	localparam int TW   = RW + 2;

	logic [VW-1:0]               v_s    [LAT];
	logic [RW-1:0]               rem_s  [LAT];
	logic [ggvc_pkg::ROOT_W-1:0] root_s [LAT];

	for (genvar j = 0; j < LAT; j++) begin : g_st
		logic [VW-1:0]               v_in;
		logic [RW-1:0]               rem_in;
		logic [ggvc_pkg::ROOT_W-1:0] root_in;

		if (j == 0) begin : g_first
			assign v_in    = VW'(radicand);
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign v_in    = v_s[j-1];
			assign rem_in  = rem_s[j-1];
			assign root_in = root_s[j-1];
		end

		if (j < ggvc_pkg::SQRT_STEPS) begin : g_step
			logic [TW-1:0] tmp;
			logic [TW-1:0] trial;

			assign tmp   = {rem_in, v_in[VW-1 -: 2]};
			assign trial = TW'({root_in, 2'b01});

			always_ff @(posedge clk) begin
				if (en) begin
					v_s[j] <= {v_in[VW-3:0], 2'b00};
					if (tmp >= trial) begin
						rem_s[j]  <= RW'(tmp - trial);
						root_s[j] <= {root_in[ggvc_pkg::ROOT_W-2:0], 1'b1};
					end else begin
						rem_s[j]  <= RW'(tmp);
						root_s[j] <= {root_in[ggvc_pkg::ROOT_W-2:0], 1'b0};
					end
				end
			end
		end else begin : g_pad
			always_ff @(posedge clk) begin
				if (en) begin
					v_s[j]    <= v_in;
					rem_s[j]  <= rem_in;
					root_s[j] <= root_in;
				end
			end
		end
	end

	assign root = root_s[LAT-1];

endmodule

/* design/ggvc_cordic.sv */
// ----------------------------------------------------------------------------
// Pipelined CORDIC vectoring unit
// Quadrant pre-rotation stage, then one micro-rotation per stage; Q30 angle.
// ----------------------------------------------------------------------------
module ggvc_cordic #(
	parameter int STEPS = ggvc_pkg::CORDIC_STEPS,
	parameter int LAT   = ggvc_pkg::CORDIC_STEPS + 1
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [ggvc_pkg::D_W-1:0]   dx,
	input  logic signed [ggvc_pkg::D_W-1:0]   dy,
	output logic signed [ggvc_pkg::Z_W-1:0]   angle
);

	localparam int CW = ggvc_pkg::CX_W;
	localparam int ZW = ggvc_pkg::Z_W;

	logic signed [CW-1:0] x_s [LAT];
	logic signed [CW-1:0] y_s [LAT];
	logic signed [ZW-1:0] z_s [LAT];

	logic signed [CW-1:0] xi;
	logic signed [CW-1:0] yi;

	assign xi = CW'(dx) <<< ggvc_pkg::PRE_SH;
	assign yi = CW'(dy) <<< ggvc_pkg::PRE_SH;

	always_ff @(posedge clk) begin
		if (en) begin
			if (xi < 0) begin
				if (yi >= 0) begin
					x_s[0] <= yi;
					y_s[0] <= -xi;
					z_s[0] <= ZW'(ggvc_pkg::HALF_PI_Q30);
				end else begin
					x_s[0] <= -yi;
					y_s[0] <= xi;
					z_s[0] <= -ZW'(ggvc_pkg::HALF_PI_Q30);
				end
			end else begin
				x_s[0] <= xi;
				y_s[0] <= yi;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar j = 1; j < LAT; j++) begin : g_st
		if (j <= STEPS) begin : g_rot
			logic signed [CW-1:0] xs;
			logic signed [CW-1:0] ys;
			assign xs = x_s[j-1] >>> (j - 1);
			assign ys = y_s[j-1] >>> (j - 1);
			always_ff @(posedge clk) begin
				if (en) begin
					if (y_s[j-1] >= 0) begin
						x_s[j] <= x_s[j-1] + ys;
						y_s[j] <= y_s[j-1] - xs;
						z_s[j] <= z_s[j-1] + ggvc_pkg::ATAN_Q30[j-1];
					end else begin
						x_s[j] <= x_s[j-1] - ys;
						y_s[j] <= y_s[j-1] + xs;
						z_s[j] <= z_s[j-1] - ggvc_pkg::ATAN_Q30[j-1];
					end
				end
			end
		end else begin : g_pad
			always_ff @(posedge clk) begin
				if (en) begin
					x_s[j] <= x_s[j-1];
					y_s[j] <= y_s[j-1];
					z_s[j] <= z_s[j-1];
				end
			end
		end
	end

	assign angle = z_s[LAT-1];

endmodule

/* design/go_to_goal_velocity_controller_unit.sv */
// ----------------------------------------------------------------------------
// Go-to-goal velocity controller
// Pose word in, one velocity command word out, proportional steering to goal.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle; square root and CORDIC are fully pipelined.
// A stalled output holds the whole pipeline until the word is taken.
// Reset clears stage valid bits and loads the default target and gains.
// ----------------------------------------------------------------------------
module go_to_goal_velocity_controller_unit #(
	parameter int CORDIC_STEPS = ggvc_pkg::CORDIC_STEPS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // pos_x[15:0], pos_y[31:16], heading[46:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // forward_speed[12:0], turn_rate[30:13]
	output logic        m_tuser,   // arrived
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);

	localparam int LAT = (ggvc_pkg::SQRT_STEPS > CORDIC_STEPS + 1) ?
		ggvc_pkg::SQRT_STEPS : CORDIC_STEPS + 1;
	localparam int DW  = ggvc_pkg::D_W;
	localparam int FB  = ggvc_pkg::FRAC_BITS;

	logic [ggvc_pkg::POS_W-1:0]  tgt_x_q;
	logic [ggvc_pkg::POS_W-1:0]  tgt_y_q;
	logic [ggvc_pkg::GAIN_W-1:0] lin_gain_q;
	logic [ggvc_pkg::GAIN_W-1:0] turn_gain_q;

	logic en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_x_q     <= 16'd12288;
			tgt_y_q     <= 16'd12288;
			lin_gain_q  <= 15'd3686;
			turn_gain_q <= 15'd2458;
		end else if (cfg_wr_en) begin
			unique case (ggvc_pkg::reg_idx_t'(cfg_addr))
				ggvc_pkg::REG_TARGET_X:  tgt_x_q     <= cfg_wdata;
				ggvc_pkg::REG_TARGET_Y:  tgt_y_q     <= cfg_wdata;
				ggvc_pkg::REG_LIN_GAIN:  lin_gain_q  <= cfg_wdata[14:0];
				ggvc_pkg::REG_TURN_GAIN: turn_gain_q <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	// valid line: s1..s3, LAT unit stages, a, b, c, out
	logic v_s1, v_s2, v_s3, v_a, v_b, v_c, v_out_q;
	logic v_u [LAT];

	assign en       = !v_out_q || m_tready;
	assign s_tready = en;
	assign m_tvalid = v_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_a     <= 1'b0;
			v_b     <= 1'b0;
			v_c     <= 1'b0;
			v_out_q <= 1'b0;
			for (int k = 0; k < LAT; k++) v_u[k] <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_u[0] <= v_s3;
			for (int k = 1; k < LAT; k++) v_u[k] <= v_u[k-1];
			v_a     <= v_u[LAT-1];
			v_b     <= v_a;
			v_c     <= v_b;
			v_out_q <= v_c;
		end
	end

	// front end: differences, squares, sum and arrival test
	logic signed [DW-1:0]      dx_s1, dy_s1, dx_s2, dy_s2, dx_s3, dy_s3;
	logic signed [ggvc_pkg::HD_W-1:0] hd_s1, hd_s2, hd_s3;
	logic [31:0]               sqx_s2, sqy_s2;
	logic [ggvc_pkg::RAD_W-1:0] d2_s3;
	logic                      arr_s3;
	logic [ggvc_pkg::RAD_W-1:0] d2_sum;

	assign d2_sum = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= $signed({1'b0, tgt_x_q}) - $signed({1'b0, s_tdata[15:0]});
			dy_s1  <= $signed({1'b0, tgt_y_q}) - $signed({1'b0, s_tdata[31:16]});
			hd_s1  <= s_tdata[46:32];
			sqx_s2 <= 32'(dx_s1 * dx_s1);
			sqy_s2 <= 32'(dy_s1 * dy_s1);
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
			hd_s2  <= hd_s1;
			d2_s3  <= d2_sum;
			arr_s3 <= d2_sum < ggvc_pkg::RAD_W'(ggvc_pkg::ARRIVE_SQ);
			dx_s3  <= dx_s2;
			dy_s3  <= dy_s2;
			hd_s3  <= hd_s2;
		end
	end

	logic [ggvc_pkg::ROOT_W-1:0]    dist_u;
	logic signed [ggvc_pkg::Z_W-1:0] ang_u;

	ggvc_sqrt #(.LAT(LAT)) u_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand (d2_s3),
		.root     (dist_u)
	);

	ggvc_cordic #(.STEPS(CORDIC_STEPS), .LAT(LAT)) u_cordic (
		.clk   (clk),
		.en    (en),
		.dx    (dx_s3),
		.dy    (dy_s3),
		.angle (ang_u)
	);

	logic signed [ggvc_pkg::HD_W-1:0] hd_u  [LAT];
	logic                             arr_u [LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			hd_u[0]  <= hd_s3;
			arr_u[0] <= arr_s3;
			for (int k = 1; k < LAT; k++) begin
				hd_u[k]  <= hd_u[k-1];
				arr_u[k] <= arr_u[k-1];
			end
		end
	end

	// back end: angle error, wrap, products, rounding and limits
	localparam int ZW = ggvc_pkg::Z_W;
	localparam int DFW = ggvc_pkg::DIFF_W;

	logic signed [ZW-1:0]  ang_rnd;
	logic signed [ggvc_pkg::BRG_W-1:0] brg;
	logic signed [DFW-1:0] diff_a, diff_b;
	logic [ggvc_pkg::ROOT_W-1:0] dist_a, dist_b;
	logic arr_a, arr_b, arr_c;
	logic signed [35:0]    tprod_c;
	logic [31:0]           sprod_c;
	logic                  gate_c;
	logic signed [DFW-1:0] absd;

	assign ang_rnd = (ang_u + (ZW'(1) <<< (ggvc_pkg::ANG_SH - 1))) >>> ggvc_pkg::ANG_SH;
	assign brg     = ang_rnd[ggvc_pkg::BRG_W-1:0];
	assign absd    = (diff_b < 0) ? -diff_b : diff_b;

	always_ff @(posedge clk) begin
		if (en) begin
			diff_a <= DFW'(brg) - DFW'(hd_u[LAT-1]);
			dist_a <= dist_u;
			arr_a  <= arr_u[LAT-1];
			if (diff_a > DFW'(ggvc_pkg::PI_Q))
				diff_b <= diff_a - DFW'(2 * ggvc_pkg::PI_Q);
			else if (diff_a < -DFW'(ggvc_pkg::PI_Q))
				diff_b <= diff_a + DFW'(2 * ggvc_pkg::PI_Q);
			else
				diff_b <= diff_a;
			dist_b  <= dist_a;
			arr_b   <= arr_a;
			tprod_c <= 36'($signed({1'b0, turn_gain_q}) * diff_b);
			sprod_c <= 32'(lin_gain_q * dist_b);
			gate_c  <= absd < DFW'(ggvc_pkg::GATE_Q);
			arr_c   <= arr_b;
		end
	end

	logic signed [35:0] turn_r;
	logic [31:0]        spd_r;
	logic [ggvc_pkg::TURN_W-1:0]  turn_f;
	logic [ggvc_pkg::SPEED_W-1:0] spd_f;
	logic [ggvc_pkg::TURN_W-1:0]  turn_q;
	logic [ggvc_pkg::SPEED_W-1:0] spd_q;
	logic                         arr_q;

	assign turn_r = (tprod_c + (36'sd1 <<< (FB - 1))) >>> FB;
	assign spd_r  = (sprod_c + (32'd1 << (FB - 1))) >> FB;

	always_comb begin
		if (turn_r > 36'(ggvc_pkg::TURN_MAX))
			turn_f = ggvc_pkg::TURN_W'(ggvc_pkg::TURN_MAX);
		else if (turn_r < 36'(ggvc_pkg::TURN_MIN))
			turn_f = ggvc_pkg::TURN_W'(ggvc_pkg::TURN_MIN);
		else
			turn_f = turn_r[ggvc_pkg::TURN_W-1:0];
		if (!gate_c)
			spd_f = '0;
		else if (spd_r > 32'(ggvc_pkg::SPEED_CAP_Q))
			spd_f = ggvc_pkg::SPEED_W'(ggvc_pkg::SPEED_CAP_Q);
		else
			spd_f = spd_r[ggvc_pkg::SPEED_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			turn_q <= arr_c ? '0 : turn_f;
			spd_q  <= arr_c ? '0 : spd_f;
			arr_q  <= arr_c;
		end
	end

	assign m_tdata = {1'b0, turn_q, spd_q};
	assign m_tuser = arr_q;

endmodule

/* design/ggvc_checker.sv */
// ----------------------------------------------------------------------------
// Go-to-goal controller port checker
// Port-level properties of the pose and command handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module ggvc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [47:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser,
	input logic        cfg_wr_en,
	input logic [1:0]  cfg_addr,
	input logic [15:0] cfg_wdata
);

	a_arrived_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[30:0] == 31'd0)
		else $error("arrived word carries nonzero speed or turn");

	a_speed_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[12:0] <= 13'd6144 && m_tdata[31] == 1'b0)
		else $error("forward speed above cap");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled output word changed");

endmodule

bind go_to_goal_velocity_controller_unit ggvc_checker u_ggvc_checker (.*);

/* tb/ggvc_checker.sv */
// ----------------------------------------------------------------------------
// Go-to-goal controller checker
// Watches the pose and command streams, predicts each command from the pose
// and the current target and gains, and compares it field by field.
// ----------------------------------------------------------------------------
module ggvc_monitor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        m_tuser,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata,
	output int          errors,
	output int          pending,
	output int          commands_seen,
	output int          arrivals_seen
);

	typedef struct packed {
		logic [ggvc_pkg::SPEED_W-1:0] speed;
		logic [ggvc_pkg::TURN_W-1:0]  turn;
		logic                         arrived;
	} command_t;

	command_t     cmd_q[$];
	logic [15:0]  goal_x, goal_y;
	logic [14:0]  lin_gain, turn_gain;

	function automatic longint floor_sh(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_sh(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint isqrt(longint v);
		longint r;
		r = 0;
		for (int b = 20; b >= 0; b--)
			if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= v)
				r = r + (64'sd1 << b);
		return r;
	endfunction

	function automatic longint bearing_q30(longint dx, longint dy);
		longint x, y, z, t, xs, ys;
		x = dx * 4096;
		y = dy * 4096;
		z = 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = ggvc_pkg::HALF_PI_Q30;
			end else begin
				t = x; x = -y; y = t; z = -ggvc_pkg::HALF_PI_Q30;
			end
		end
		for (int i = 0; i < ggvc_pkg::CORDIC_STEPS && i < ggvc_pkg::ATAN_LEN; i++) begin
			xs = floor_sh(x, i);
			ys = floor_sh(y, i);
			if (y >= 0) begin
				x = x + ys; y = y - xs; z += ggvc_pkg::ATAN_Q30[i];
			end else begin
				x = x - ys; y = y + xs; z -= ggvc_pkg::ATAN_Q30[i];
			end
		end
		return z;
	endfunction

	function automatic command_t steer(logic [47:0] pose);
		command_t c;
		longint dx, dy, d2, root_d, hd, diff, turn, speed, absd;
		c = '0;
		hd = longint'($signed(pose[46:32]));
		dx = longint'(goal_x) - longint'(pose[15:0]);
		dy = longint'(goal_y) - longint'(pose[31:16]);
		d2 = dx * dx + dy * dy;
		if (d2 < ggvc_pkg::ARRIVE_SQ) begin
			c.arrived = 1'b1;
			return c;
		end
		root_d = isqrt(d2);
		diff = round_sh(bearing_q30(dx, dy), ggvc_pkg::ANG_SH) - hd;
		if (diff > ggvc_pkg::PI_Q)
			diff -= 2 * ggvc_pkg::PI_Q;
		else if (diff < -ggvc_pkg::PI_Q)
			diff += 2 * ggvc_pkg::PI_Q;
		turn = round_sh(longint'(turn_gain) * diff, ggvc_pkg::FRAC_BITS);
		if (turn > ggvc_pkg::TURN_MAX) turn = ggvc_pkg::TURN_MAX;
		if (turn < ggvc_pkg::TURN_MIN) turn = ggvc_pkg::TURN_MIN;
		absd = diff < 0 ? -diff : diff;
		speed = 0;
		if (absd < ggvc_pkg::GATE_Q) begin
			speed = round_sh(longint'(lin_gain) * root_d, ggvc_pkg::FRAC_BITS);
			if (speed > ggvc_pkg::SPEED_CAP_Q) speed = ggvc_pkg::SPEED_CAP_Q;
		end
		c.speed = speed[ggvc_pkg::SPEED_W-1:0];
		c.turn = turn[ggvc_pkg::TURN_W-1:0];
		return c;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		command_t want;
		if (!arst_n) begin
			goal_x = 16'd12288;
			goal_y = 16'd12288;
			lin_gain = 15'd3686;
			turn_gain = 15'd2458;
			cmd_q.delete();
			errors = 0;
			pending = 0;
			commands_seen = 0;
			arrivals_seen = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				commands_seen++;
				if (m_tuser) arrivals_seen++;
				if (cmd_q.size() == 0) begin
					report("unexpected word", m_tdata, 0);
				end else begin
					want = cmd_q.pop_front();
					if (m_tdata[12:0] !== want.speed)
						report("forward_speed", m_tdata[12:0], want.speed);
					if (m_tdata[30:13] !== want.turn)
						report("turn_rate", $signed(m_tdata[30:13]), $signed(want.turn));
					if (m_tuser !== want.arrived)
						report("arrived", m_tuser, want.arrived);
				end
			end
			if (s_tvalid && s_tready)
				cmd_q.push_back(steer(s_tdata));
			pending = cmd_q.size();
			if (cfg_wr_en) begin
				case (ggvc_pkg::reg_idx_t'(cfg_addr))
					ggvc_pkg::REG_TARGET_X:  goal_x = cfg_wdata;
					ggvc_pkg::REG_TARGET_Y:  goal_y = cfg_wdata;
					ggvc_pkg::REG_LIN_GAIN:  lin_gain = cfg_wdata[14:0];
					ggvc_pkg::REG_TURN_GAIN: turn_gain = cfg_wdata[14:0];
				endcase
			end
		end
	end
endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// Go-to-goal controller testbench
// Drives pose words under several target and gain settings with random idle
// bursts on both streams; the checker predicts and compares every command.
// ----------------------------------------------------------------------------
module tb;

	localparam int LIMIT = 400000;

	logic        clk, arst_n;
	logic        s_tvalid, s_tready, m_tvalid, m_tready, m_tuser;
	logic [47:0] s_tdata;
	logic [31:0] m_tdata;
	logic        cfg_wr_en;
	logic [1:0]  cfg_addr;
	logic [15:0] cfg_wdata;
	int          errors, pending, commands_seen, arrivals_seen;
	int          cycles;
	bit          calm;
	logic [15:0] cur_x, cur_y;

	go_to_goal_velocity_controller_unit i_dut (.*);

	ggvc_monitor i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("status: fail");
				$finish;
			end
		end
	end

	// random output stall bursts
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 3) - 1) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send(logic [15:0] px, logic [15:0] py, logic [14:0] hd);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, hd, py, px};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(ggvc_pkg::reg_idx_t idx, logic [15:0] v);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == ggvc_pkg::REG_TARGET_X) cur_x = v;
		if (idx == ggvc_pkg::REG_TARGET_Y) cur_y = v;
	endtask

	function automatic logic [14:0] rand_heading();
		int h;
		h = $urandom_range(0, 4) == 0 ? $urandom_range(0, 32767) - 16384
			: $urandom_range(0, 25736) - 12868;
		return h[14:0];
	endfunction

	task automatic random_pose();
		int k;
		k = $urandom_range(0, 9);
		if (k < 2)
			send(cur_x + 16'($urandom_range(0, 800) - 400),
				cur_y + 16'($urandom_range(0, 800) - 400), rand_heading());
		else if (k < 4)
			send(cur_x + 16'($urandom_range(0, 16000) - 8000),
				cur_y + 16'($urandom_range(0, 16000) - 8000), rand_heading());
		else
			send(16'($urandom), 16'($urandom), rand_heading());
	endtask

	initial begin
		logic [15:0] gx [6] = '{16'd12288, 16'd0, 16'hFFFF, 16'd32768, 16'd5000, 16'd0};
		logic [15:0] gy [6] = '{16'd12288, 16'hFFFF, 16'd0, 16'd32768, 16'd40000, 16'd0};
		logic [15:0] lg [6] = '{16'd3686, 16'd0, 16'h7FFF, 16'd4096, 16'd1000, 16'd20000};
		logic [15:0] tg [6] = '{16'd2458, 16'h7FFF, 16'd0, 16'd8192, 16'd20000, 16'd1};
		arst_n = 1'b0;
		calm = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_wr_en = 1'b0;
		cfg_addr = ggvc_pkg::REG_TARGET_X;
		cfg_wdata = '0;
		cur_x = 16'd12288;
		cur_y = 16'd12288;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// edges of the pose fields, arrival boundary, wrap and gate cases
		send(16'd12288, 16'd12288, 15'd0);
		send(16'd12288 + 16'd409, 16'd12288, 15'd0);
		send(16'd12288 + 16'd410, 16'd12288, 15'd0);
		send(16'd12288 - 16'd289, 16'd12288 - 16'd289, 15'd0);
		send(16'd0, 16'd0, 15'd0);
		send(16'hFFFF, 16'hFFFF, 15'd0);
		send(16'd0, 16'hFFFF, 15'h7FFF);
		send(16'hFFFF, 16'd0, 15'h4000);
		send(16'd0, 16'd12288, 15'd12868);
		send(16'd0, 16'd12288, -15'sd12868);
		send(16'd20000, 16'd12288, 15'd12868);
		send(16'd20000, 16'd12288, -15'sd12868);
		send(16'd20000, 16'd12290, 15'd0);
		send(16'd20000, 16'd12286, 15'd0);
		send(16'd0, 16'd0, 15'd3216 + 15'd3686);
		send(16'd0, 16'd0, 15'd3216 + 15'd3680);
		send(16'd12288, 16'd0, 15'd6434);
		send(16'd12288, 16'd30000, -15'sd6434);
		send(16'hAAAA, 16'h5555, 15'h2AAA);
		send(16'h5555, 16'hAAAA, 15'h5555);
		drain();

		for (int ph = 1; ph < 6; ph++) begin
			write_reg(ggvc_pkg::REG_TARGET_X, gx[ph]);
			write_reg(ggvc_pkg::REG_TARGET_Y, gy[ph]);
			write_reg(ggvc_pkg::REG_LIN_GAIN, lg[ph]);
			write_reg(ggvc_pkg::REG_TURN_GAIN, tg[ph]);
			if (ph == 5) calm = 1'b1;
			repeat (240) random_pose();
			drain();
		end

		$display("covered %0d commands, %0d arrivals, six target and gain settings",
			commands_seen, arrivals_seen);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
